/* design/glp_pkg.sv */
// Shared types, constants and the trial offset table for the greedy label placer.
// No dependencies; used by glp_ram users and greedy_label_placer_top.
`timescale 1ns / 1ps

package glp_pkg;

  localparam int MAX_BOXES   = 64;
  localparam int IDX_W       = (MAX_BOXES > 1) ? $clog2(MAX_BOXES) : 1;
  localparam int CNT_W       = $clog2(MAX_BOXES + 1);
  localparam int NUM_OFFSETS = 13;
  localparam int K_W         = 4;
  localparam int BOX_W       = 64;
  localparam int CFG_AW      = 5;
  localparam int CRD_W       = 18;  // candidate coordinate width, signed

  // register indexes (paddr[4:2])
  localparam logic [2:0] REG_BOUND_LEFT   = 3'd0;
  localparam logic [2:0] REG_BOUND_TOP    = 3'd1;
  localparam logic [2:0] REG_BOUND_RIGHT  = 3'd2;
  localparam logic [2:0] REG_BOUND_BOTTOM = 3'd3;
  localparam logic [2:0] REG_PAD_PX       = 3'd4;

  typedef struct packed {
    logic               new_pass;
    logic signed [15:0] anchor_x;
    logic signed [15:0] anchor_y;
    logic [11:0]        text_width;
    logic [7:0]         text_height;
    logic [3:0]         text_scale;
  } req_t;

  typedef struct packed {
    logic               placed;
    logic signed [15:0] box_x;
    logic signed [15:0] box_y;
    logic [12:0]        box_w;
    logic [9:0]         box_h;
    logic               store_full;
  } res_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PREP,
    ST_OFFS,
    ST_BCHK,
    ST_SCAN,
    ST_FINISH
  } state_t;

  function automatic logic signed [5:0] trial_dx(input logic [K_W-1:0] k);
    logic signed [5:0] d;
    case (k)
      4'd3:    d = -6'sd8;
      4'd4:    d = 6'sd8;
      4'd5:    d = -6'sd10;
      4'd6:    d = 6'sd10;
      4'd7:    d = -6'sd10;
      4'd8:    d = 6'sd10;
      4'd11:   d = -6'sd16;
      4'd12:   d = 6'sd16;
      default: d = 6'sd0;
    endcase
    return d;
  endfunction

  function automatic logic signed [5:0] trial_dy(input logic [K_W-1:0] k);
    logic signed [5:0] d;
    case (k)
      4'd1:    d = -6'sd8;
      4'd2:    d = 6'sd8;
      4'd5:    d = -6'sd10;
      4'd6:    d = -6'sd10;
      4'd7:    d = 6'sd10;
      4'd8:    d = 6'sd10;
      4'd9:    d = -6'sd16;
      4'd10:   d = 6'sd16;
      default: d = 6'sd0;
    endcase
    return d;
  endfunction

endpackage

/* design/glp_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module glp_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 64
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* design/greedy_label_placer_top.sv */
// Greedy label placer: up to 13 offset trials per request, one stored box compared
// per cycle. A zero-size request or a full store skips the trials. busy drops after
// the strobe. Throughput: one request at a time, set by the box RAM scan (one
// registered read/cycle). Strobe lasts one cycle; the receiver cannot stall.
// Sync active-low reset clears control, config registers and the box count, not the box
// RAM. Depends on glp_pkg and glp_ram.
`timescale 1ns / 1ps

module greedy_label_placer_top (
  input  logic                            clk,
  input  logic                            rst_n,
  // request channel
  input  logic                            start,
  output logic                            busy,
  input  glp_pkg::req_t                   in_req,
  // result channel
  output logic                            out_strobe,
  output glp_pkg::res_t                   out_res,
  // config port
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [glp_pkg::CFG_AW-1:0]      paddr,
  input  logic [31:0]                     pwdata,
  output logic [31:0]                     prdata,
  output logic                            pready
);

  localparam int IW = glp_pkg::IDX_W;
  localparam int CW = glp_pkg::CNT_W;
  localparam int KW = glp_pkg::K_W;
  localparam int DW = glp_pkg::CRD_W;

  glp_pkg::state_t state_r, state_nxt;

  logic [14:0] bnd_left_r, bnd_top_r, bnd_right_r, bnd_bottom_r;
  logic [7:0]  pad_r;

  logic signed [15:0] ax_r, ay_r;
  logic [12:0]        w_r, w_nxt;
  logic [9:0]         h_r, h_nxt;
  logic [3:0]         sc_r, sc_nxt;
  logic [KW-1:0]      k_r, k_nxt;
  logic [IW-1:0]      scan_i_r, scan_i_nxt;
  logic [CW-1:0]      count_r, count_nxt;
  logic signed [DW-1:0] cand_l_r, cand_t_r, cand_l_nxt, cand_t_nxt;
  logic [15:0]        cand_r_r, cand_b_r;
  logic               placed_r, placed_nxt, full_r, full_nxt;

  logic accept, cfg_wr;
  logic [2:0] reg_idx;

  logic signed [5:0]    dx, dy;
  logic signed [10:0]   off_x, off_y;
  logic signed [DW-1:0] right_c, bottom_c;
  logic                 bounds_ok, touch, last_k, last_i, zero_size, store_full_c;

  logic            ram_we;
  logic [IW-1:0]   ram_waddr, ram_raddr;
  logic [63:0]     ram_wdata, ram_q;
  logic [15:0]     s_l, s_t, s_r, s_b;

  assign accept  = start && !busy;
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign reg_idx = paddr[4:2];
  assign pready  = 1'b1;

  // config registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bnd_left_r   <= 15'd0;
      bnd_top_r    <= 15'd0;
      bnd_right_r  <= 15'h7FFF;
      bnd_bottom_r <= 15'h7FFF;
      pad_r        <= 8'd0;
    end else if (cfg_wr) begin
      case (reg_idx)
        glp_pkg::REG_BOUND_LEFT:   bnd_left_r   <= pwdata[14:0];
        glp_pkg::REG_BOUND_TOP:    bnd_top_r    <= pwdata[14:0];
        glp_pkg::REG_BOUND_RIGHT:  bnd_right_r  <= pwdata[14:0];
        glp_pkg::REG_BOUND_BOTTOM: bnd_bottom_r <= pwdata[14:0];
        glp_pkg::REG_PAD_PX:       pad_r        <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      glp_pkg::REG_BOUND_LEFT:   prdata = {17'd0, bnd_left_r};
      glp_pkg::REG_BOUND_TOP:    prdata = {17'd0, bnd_top_r};
      glp_pkg::REG_BOUND_RIGHT:  prdata = {17'd0, bnd_right_r};
      glp_pkg::REG_BOUND_BOTTOM: prdata = {17'd0, bnd_bottom_r};
      glp_pkg::REG_PAD_PX:       prdata = {24'd0, pad_r};
      default:                   prdata = 32'd0;
    endcase
  end

  // shared datapath: offset scaling and candidate corner, then bounds, then overlap
  assign dx    = glp_pkg::trial_dx(k_r);
  assign dy    = glp_pkg::trial_dy(k_r);
  assign off_x = 11'(dx) * 11'($signed({1'b0, sc_r}));
  assign off_y = 11'(dy) * 11'($signed({1'b0, sc_r}));

  assign right_c  = cand_l_r + DW'($signed({1'b0, w_r})) - DW'(1);
  assign bottom_c = cand_t_r + DW'($signed({1'b0, h_r})) - DW'(1);
  assign bounds_ok = (cand_l_r >= $signed({3'b000, bnd_left_r}))
                  && (cand_t_r >= $signed({3'b000, bnd_top_r}))
                  && (right_c  <= $signed({3'b000, bnd_right_r}))
                  && (bottom_c <= $signed({3'b000, bnd_bottom_r}));

  // stored entry layout: {left, top, right, bottom}
  assign s_l = ram_q[63:48];
  assign s_t = ram_q[47:32];
  assign s_r = ram_q[31:16];
  assign s_b = ram_q[15:0];
  // inclusive corners: touching counts as overlap
  assign touch = !((cand_r_r < s_l) || (s_r < cand_l_r[15:0])
                || (cand_b_r < s_t) || (s_b < cand_t_r[15:0]));

  assign last_k       = (k_r == KW'(glp_pkg::NUM_OFFSETS - 1));
  assign last_i       = ((CW'(scan_i_r) + CW'(1)) == count_r);
  assign zero_size    = (w_r == 13'd0) || (h_r == 10'd0);
  assign store_full_c = (count_r == CW'(glp_pkg::MAX_BOXES));

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      glp_pkg::ST_IDLE: begin
        if (accept) state_nxt = glp_pkg::ST_PREP;
      end
      glp_pkg::ST_PREP: begin
        if (zero_size || store_full_c) state_nxt = glp_pkg::ST_FINISH;
        else                           state_nxt = glp_pkg::ST_OFFS;
      end
      glp_pkg::ST_OFFS: state_nxt = glp_pkg::ST_BCHK;
      glp_pkg::ST_BCHK: begin
        if (!bounds_ok)           state_nxt = last_k ? glp_pkg::ST_FINISH : glp_pkg::ST_OFFS;
        else if (count_r == '0)   state_nxt = glp_pkg::ST_FINISH;
        else                      state_nxt = glp_pkg::ST_SCAN;
      end
      glp_pkg::ST_SCAN: begin
        if (touch)       state_nxt = last_k ? glp_pkg::ST_FINISH : glp_pkg::ST_OFFS;
        else if (last_i) state_nxt = glp_pkg::ST_FINISH;
      end
      glp_pkg::ST_FINISH: state_nxt = glp_pkg::ST_IDLE;
      default: state_nxt = glp_pkg::ST_IDLE;
    endcase
  end

  // datapath next values
  always_comb begin
    w_nxt      = w_r;
    h_nxt      = h_r;
    sc_nxt     = sc_r;
    k_nxt      = k_r;
    scan_i_nxt = scan_i_r;
    count_nxt  = count_r;
    cand_l_nxt = cand_l_r;
    cand_t_nxt = cand_t_r;
    placed_nxt = placed_r;
    full_nxt   = full_r;
    case (state_r)
      glp_pkg::ST_IDLE: begin
        if (accept) begin
          w_nxt      = {1'b0, in_req.text_width} + {4'd0, pad_r, 1'b0};
          h_nxt      = {2'd0, in_req.text_height} + {1'b0, pad_r, 1'b0};
          sc_nxt     = (in_req.text_scale == 4'd0) ? 4'd1 : in_req.text_scale;
          k_nxt      = '0;
          placed_nxt = 1'b0;
          full_nxt   = 1'b0;
          if (in_req.new_pass) count_nxt = '0;
        end
      end
      glp_pkg::ST_PREP: begin
        if (!zero_size && store_full_c) full_nxt = 1'b1;
      end
      glp_pkg::ST_OFFS: begin
        cand_l_nxt = DW'(ax_r) + DW'(off_x) - DW'($signed({1'b0, w_r[12:1]}));
        cand_t_nxt = DW'(ay_r) + DW'(off_y) - DW'($signed({1'b0, h_r[9:1]}));
      end
      glp_pkg::ST_BCHK: begin
        scan_i_nxt = '0;
        if (!bounds_ok)         k_nxt = k_r + KW'(1);
        else if (count_r == '0) placed_nxt = 1'b1;
      end
      glp_pkg::ST_SCAN: begin
        if (touch)       k_nxt = k_r + KW'(1);
        else if (last_i) placed_nxt = 1'b1;
        else             scan_i_nxt = scan_i_r + IW'(1);
      end
      glp_pkg::ST_FINISH: begin
        if (placed_r) count_nxt = count_r + CW'(1);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= glp_pkg::ST_IDLE;
      count_r  <= '0;
      k_r      <= '0;
      scan_i_r <= '0;
      placed_r <= 1'b0;
      full_r   <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      count_r  <= count_nxt;
      k_r      <= k_nxt;
      scan_i_r <= scan_i_nxt;
      placed_r <= placed_nxt;
      full_r   <= full_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (accept) begin
      ax_r <= in_req.anchor_x;
      ay_r <= in_req.anchor_y;
    end
    w_r      <= w_nxt;
    h_r      <= h_nxt;
    sc_r     <= sc_nxt;
    cand_l_r <= cand_l_nxt;
    cand_t_r <= cand_t_nxt;
    if (state_r == glp_pkg::ST_BCHK) begin
      cand_r_r <= right_c[15:0];
      cand_b_r <= bottom_c[15:0];
    end
  end

  // outputs and RAM control
  always_comb begin
    busy       = (state_r != glp_pkg::ST_IDLE);
    out_strobe = (state_r == glp_pkg::ST_FINISH);
    out_res.placed     = placed_r;
    out_res.box_x      = placed_r ? cand_l_r[15:0] : 16'sd0;
    out_res.box_y      = placed_r ? cand_t_r[15:0] : 16'sd0;
    out_res.box_w      = w_r;
    out_res.box_h      = h_r;
    out_res.store_full = full_r;
    ram_we    = (state_r == glp_pkg::ST_FINISH) && placed_r;
    ram_waddr = count_r[IW-1:0];
    ram_wdata = {cand_l_r[15:0], cand_t_r[15:0], cand_r_r, cand_b_r};
    // prefetch: entry 0 during bounds check, next entry during scan
    ram_raddr = (state_r == glp_pkg::ST_SCAN) ? (scan_i_r + IW'(1)) : '0;
  end

  glp_ram #(
    .WIDTH (glp_pkg::BOX_W),
    .DEPTH (glp_pkg::MAX_BOXES)
  ) u_box_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_q)
  );

  // checks
  a_excl_flags: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> !(out_res.placed && out_res.store_full))
    else $error("placed and store_full both set");

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> (busy && !out_strobe))
    else $error("request accepted without going busy");

  a_strobe_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |=> !busy)
    else $error("not idle after result");

  a_count_max: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && out_res.placed) |-> (count_r < CW'(glp_pkg::MAX_BOXES)))
    else $error("box stored into full store");

endmodule
